/* sv/rths_pkg.sv */
`default_nettype none
package rths_pkg;

    localparam int CH_W       = 8;
    localparam int QUO_W      = 8;
    // sector numerator stays below 6 * 255
    localparam int SECT_W     = 11;
    localparam int HUE_NUM_W  = 19;
    localparam int HUE_DEN_W  = 11;
    localparam int SAT_NUM_W  = 17;
    localparam int SAT_DEN_W  = 10;
    // doubled scales: round(a/b) = floor((2a + b) / 2b)
    localparam int HUE_SCALE2 = 254;
    localparam int SAT_SCALE2 = 508;
    localparam int FRONT_STAGES = 2;
    localparam int LATENCY    = FRONT_STAGES + QUO_W + 1;

    typedef struct packed {
        logic                 valid;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DEN_W-1:0] sat_den;
    } div_req_t;

endpackage
`default_nettype wire

/* sv/rths_front.sv */
`default_nettype none
module rths_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [rths_pkg::CH_W-1:0] red,
    input  wire logic [rths_pkg::CH_W-1:0] green,
    input  wire logic [rths_pkg::CH_W-1:0] blue,
    output rths_pkg::div_req_t         req
);
    import rths_pkg::*;

    logic              va_reg;
    logic [CH_W-1:0]   max_reg, max_next;
    logic [CH_W-1:0]   d_reg, d_next;
    logic [SECT_W-1:0] num_reg, num_next;
    div_req_t          req_reg, req_next;

    logic [CH_W-1:0]   mn;
    logic [11:0]       t;
    logic [11:0]       d12;

    // stage a: extremes, delta and sector numerator
    always_comb
    begin
        max_next = red;
        mn       = red;
        if (green > max_next) max_next = green;
        if (blue > max_next) max_next = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d_next = max_next - mn;
        d12    = 12'(d_next);
        priority if (red >= green && red >= blue)
        begin
            t = 12'(green) - 12'(blue);
            if (green < blue) t = t + d12 * 12'd6;
        end
        else if (green >= blue)
        begin
            t = 12'(blue) - 12'(red) + d12 * 12'd2;
        end
        else
        begin
            t = 12'(red) - 12'(green) + d12 * 12'd4;
        end
        num_next = SECT_W'(t);
    end

    // stage b: scaled dividends and divisors, zero divisors replaced
    always_comb
    begin
        req_next.valid   = va_reg;
        req_next.hue_num = HUE_NUM_W'(num_reg) * HUE_NUM_W'(HUE_SCALE2)
                           + HUE_NUM_W'(d_reg) * HUE_NUM_W'(3);
        req_next.hue_den = (d_reg == '0) ? HUE_DEN_W'(6)
                           : HUE_DEN_W'(d_reg) * HUE_DEN_W'(6);
        req_next.sat_num = SAT_NUM_W'(d_reg) * SAT_NUM_W'(SAT_SCALE2)
                           + SAT_NUM_W'(max_reg);
        req_next.sat_den = (max_reg == '0) ? SAT_DEN_W'(2)
                           : SAT_DEN_W'(max_reg) * SAT_DEN_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            req_reg <= '0;
        end
        else
        begin
            va_reg  <= in_valid;
            req_reg <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        d_reg   <= d_next;
        num_reg <= num_next;
    end

    assign req = req_reg;

endmodule
`default_nettype wire

/* sv/rths_divider.sv */
`default_nettype none
// restoring division, one quotient bit per stage; quotient must fit QUO_W bits
module rths_divider #(
    parameter int NUM_W = rths_pkg::HUE_NUM_W,
    parameter int DEN_W = rths_pkg::HUE_DEN_W,
    parameter int QUO_W = rths_pkg::QUO_W
) (
    input  wire logic             clk,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);
    import rths_pkg::*;

    logic [NUM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] sub;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign sub  = NUM_W'(den_in) << SH;
        assign take = (rem_in >= sub);

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= take ? (quo_in | (QUO_W'(1) << SH)) : quo_in;
        end

        if (k < QUO_W - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= take ? (rem_in - sub) : rem_in;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule
`default_nettype wire

/* sv/rgb_to_hue_saturation_top.sv */
`default_nettype none
// RGB pixel to hue and saturation, both on 0..254. A pixel is taken on any
// cycle with start high (busy is never raised) and its result appears with
// done high after it passes the front stages, which form the extremes, sector
// numerator and scaled operands, the two restoring dividers, which produce
// one quotient bit per stage, and the output register. One pixel per clock
// is sustained; results cannot be held off, so take them on done.
module rgb_to_hue_saturation_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [rths_pkg::CH_W-1:0] red_in,
    input  wire logic [rths_pkg::CH_W-1:0] green_in,
    input  wire logic [rths_pkg::CH_W-1:0] blue_in,
    output logic                           done,
    output logic [rths_pkg::CH_W-1:0]      hue_out,
    output logic [rths_pkg::CH_W-1:0]      saturation_out
);
    import rths_pkg::*;

    div_req_t         req;
    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] sat_q;
    logic [QUO_W-1:0] vld_reg, vld_next;
    logic             done_reg;
    logic [CH_W-1:0]  hue_reg;
    logic [CH_W-1:0]  sat_reg;

    assign busy = 1'b0;

    rths_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .red      (red_in),
        .green    (green_in),
        .blue     (blue_in),
        .req      (req)
    );

    rths_divider #(
        .NUM_W (HUE_NUM_W),
        .DEN_W (HUE_DEN_W),
        .QUO_W (QUO_W)
    ) u_hue_div (
        .clk (clk),
        .num (req.hue_num),
        .den (req.hue_den),
        .quo (hue_q)
    );

    rths_divider #(
        .NUM_W (SAT_NUM_W),
        .DEN_W (SAT_DEN_W),
        .QUO_W (QUO_W)
    ) u_sat_div (
        .clk (clk),
        .num (req.sat_num),
        .den (req.sat_den),
        .quo (sat_q)
    );

    // item valid travels alongside the divider stages
    assign vld_next = {vld_reg[QUO_W-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= CH_W'(hue_q);
        sat_reg <= CH_W'(sat_q);
    end

    assign done           = done_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;

endmodule
`default_nettype wire

/* sv/rths_checker.sv */
`default_nettype none
module rths_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic [rths_pkg::CH_W-1:0] red_in,
    input wire logic [rths_pkg::CH_W-1:0] green_in,
    input wire logic [rths_pkg::CH_W-1:0] blue_in,
    input wire logic                      done,
    input wire logic [rths_pkg::CH_W-1:0] hue_out,
    input wire logic [rths_pkg::CH_W-1:0] saturation_out
);
    import rths_pkg::*;

    localparam int CNT_W = $clog2(LATENCY + 1);

    logic [CNT_W-1:0] warm_reg, warm_next;

    // cycles since reset, saturating once the pipeline has filled
    assign warm_next = (warm_reg == CNT_W'(LATENCY)) ? warm_reg : warm_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else
        begin
            warm_reg <= warm_next;
        end
    end

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_item_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg == CNT_W'(LATENCY)) && $past(start && !busy, LATENCY) |-> done)
        else $error("accepted item not delivered");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(red_in == green_in && green_in == blue_in, LATENCY)
        |-> hue_out == '0 && saturation_out == '0)
        else $error("grey pixel gave non-zero hue or saturation");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue_out != 8'd255 && saturation_out != 8'd255)
        else $error("result above 254");

endmodule

bind rgb_to_hue_saturation_top rths_checker u_rths_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .done           (done),
    .hue_out        (hue_out),
    .saturation_out (saturation_out)
);
`default_nettype wire

/* sim/tb_rgb_to_hue_saturation_top.sv */
`timescale 1ns / 1ps

typedef logic [rths_pkg::CH_W-1:0] channel_t;

typedef struct packed {
    logic [rths_pkg::CH_W-1:0] hue;
    logic [rths_pkg::CH_W-1:0] sat;
} hue_sat_t;

class hue_sat_board;
    hue_sat_t expected_q[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    task report_mismatch(string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    // exact rational arithmetic, halves rounded away from zero
    function hue_sat_t predict_hue_sat(logic [rths_pkg::CH_W-1:0] r,
                                       logic [rths_pkg::CH_W-1:0] g,
                                       logic [rths_pkg::CH_W-1:0] b);
        int       mx;
        int       mn;
        int       d;
        int       num;
        int       hue;
        int       sat;
        hue_sat_t res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue = 0;
        sat = 0;
        if (d > 0)
        begin
            // red wins a tie for the largest, then green
            if (mx == r)
            begin
                num = int'(g) - int'(b);
                if (num < 0) num += 6 * d;
            end
            else if (mx == g)
            begin
                num = int'(b) - int'(r) + 2 * d;
            end
            else
            begin
                num = int'(r) - int'(g) + 4 * d;
            end
            hue = (2 * 127 * num + 3 * d) / (6 * d);
        end
        if (mx > 0)
            sat = (2 * 254 * d + mx) / (2 * mx);
        if (hue > 255) hue = 255;
        if (sat > 255) sat = 255;
        res.hue = hue[rths_pkg::CH_W-1:0];
        res.sat = sat[rths_pkg::CH_W-1:0];
        return res;
    endfunction

    function void note_pixel(logic [rths_pkg::CH_W-1:0] r,
                             logic [rths_pkg::CH_W-1:0] g,
                             logic [rths_pkg::CH_W-1:0] b);
        expected_q.push_back(predict_hue_sat(r, g, b));
    endfunction

    task check_result(logic [rths_pkg::CH_W-1:0] hue, logic [rths_pkg::CH_W-1:0] sat);
        hue_sat_t exp_hs;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("result hue=%0d sat=%0d with no pixel pending", hue, sat));
        end
        else
        begin
            exp_hs = expected_q.pop_front();
            if (hue !== exp_hs.hue)
                report_mismatch($sformatf("hue_out %0d, expected %0d", hue, exp_hs.hue));
            if (sat !== exp_hs.sat)
                report_mismatch($sformatf("saturation_out %0d, expected %0d", sat, exp_hs.sat));
        end
    endtask

    task check_drained();
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
endclass

module tb_rgb_to_hue_saturation_top;

    localparam int RANDOM_PIXELS = 1400;
    localparam int IDLE_LIMIT    = 500;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [rths_pkg::CH_W-1:0] red_in;
    logic [rths_pkg::CH_W-1:0] green_in;
    logic [rths_pkg::CH_W-1:0] blue_in;
    logic                      done;
    logic [rths_pkg::CH_W-1:0] hue_out;
    logic [rths_pkg::CH_W-1:0] saturation_out;

    hue_sat_board board;
    int           idle_cycles;

    rgb_to_hue_saturation_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .done           (done),
        .hue_out        (hue_out),
        .saturation_out (saturation_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // inputs and results sampled before the edge updates anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_pixel(red_in, green_in, blue_in);
            if (done)
                board.check_result(hue_out, saturation_out);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_rgb_to_hue_saturation_top NOT OK");
                $finish;
            end
        end
    end

    // holds the item until the block takes it
    task send_pixel(logic [rths_pkg::CH_W-1:0] r, logic [rths_pkg::CH_W-1:0] g,
                    logic [rths_pkg::CH_W-1:0] b);
        start    <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [rths_pkg::CH_W-1:0] clip_channel(int v);
        if (v < 0) return '0;
        if (v > 255) return '1;
        return v[rths_pkg::CH_W-1:0];
    endfunction

    task rand_pixel(output logic [rths_pkg::CH_W-1:0] r, output logic [rths_pkg::CH_W-1:0] g,
                    output logic [rths_pkg::CH_W-1:0] b);
        int base;
        int pick;
        r    = channel_t'($urandom_range(0, 255));
        g    = channel_t'($urandom_range(0, 255));
        b    = channel_t'($urandom_range(0, 255));
        base = $urandom_range(0, 255);
        pick = $urandom_range(0, 9);
        case (pick)
            4, 5:
            begin
                // two or three channels tied
                case ($urandom_range(0, 3))
                    0: g = r;
                    1: b = r;
                    2: b = g;
                    default:
                    begin
                        g = r;
                        b = r;
                    end
                endcase
            end
            6, 7:
            begin
                // near grey, tiny spread
                r = clip_channel(base + $urandom_range(0, 6) - 3);
                g = clip_channel(base + $urandom_range(0, 6) - 3);
                b = clip_channel(base + $urandom_range(0, 6) - 3);
            end
            8:
            begin
                r = channel_t'($urandom_range(0, 3));
                g = channel_t'($urandom_range(0, 3));
                b = channel_t'($urandom_range(0, 3));
            end
            9:
            begin
                r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        logic [rths_pkg::CH_W-1:0] r;
        logic [rths_pkg::CH_W-1:0] g;
        logic [rths_pkg::CH_W-1:0] b;
        int                        sent;
        int                        burst;
        int                        k;
        board       = new();
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // black, white, grey
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        // primaries and secondaries, ties for the largest channel
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        // red largest with green below blue wraps the sector
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd1, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd255);
        pause(3);
        // smallest nonzero maximum and smallest spreads
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd2, 8'd1, 8'd3);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd85, 8'd170, 8'd255);
        pause(2);

        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < RANDOM_PIXELS; k++)
            begin
                rand_pixel(r, g, b);
                send_pixel(r, g, b);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 12));
        end
        start <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (rths_pkg::LATENCY + 4) @(posedge clk);
        board.check_drained();
        if (board.errors == 0)
            $display("tb_rgb_to_hue_saturation_top OK");
        else
            $display("tb_rgb_to_hue_saturation_top NOT OK");
        $finish;
    end

endmodule

/* rgb_to_hue_saturation_top.f */
sv/rths_pkg.sv
sv/rths_front.sv
sv/rths_divider.sv
sv/rgb_to_hue_saturation_top.sv
sv/rths_checker.sv
sim/tb_rgb_to_hue_saturation_top.sv
